// File: rtl/bounded_ordered_list_assert.svh
// ----------------------------------------------------------------------------
// bounded_ordered_list assertion macros
// Clocked property shorthands used by the list RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BOL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BOL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bol_pkg.sv
// ----------------------------------------------------------------------------
// bol_pkg
// Types and constants for the bounded ordered list and its cells.
// ----------------------------------------------------------------------------
package bol_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;
    localparam int VALUE_W  = 32;

    typedef enum logic [1:0] {
        CMD_INS_ORDERED = 2'd0,
        CMD_INS_FRONT   = 2'd1,
        CMD_INS_BACK    = 2'd2,
        CMD_REMOVE      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                       cmd;
        logic signed [VALUE_W-1:0]  value;
    } t_item;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   count;
    } t_result;

    // One stored entry as it moves between neighbors.
    typedef struct packed {
        logic                       valid;
        logic signed [VALUE_W-1:0]  value;
    } t_slot;

    // Operation broadcast to every cell for one beat.
    typedef struct packed {
        logic                       ins;
        logic                       rem;
        t_cmd                       cmd;
        logic signed [VALUE_W-1:0]  value;
    } t_op;

endpackage

// File: rtl/bounded_ordered_list.sv
// A result strobes on o_valid in the cycle after its beat is taken.
// Throughput: one beat per cycle; busy stays low, since the whole cell row
// compares and shifts as each beat is taken.
// Reset (i_rst_n low, synchronous): list empty, count zero, no result pending.
// The receiver cannot stall: each result shows for one cycle only.
// ----------------------------------------------------------------------------
// bounded_ordered_list
// Descending ordered list of signed 32-bit values built as a row of cells,
// supporting ordered, front and back insert plus remove-first-match.
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_assert.svh"

module bounded_ordered_list (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bol_pkg::t_item    i_item,
    output logic              o_valid,
    output bol_pkg::t_result  o_result
);

    localparam int N = bol_pkg::CAPACITY;

    // Row wiring: found ripples left to right, slots are read by both neighbors.
    logic            found [N+1];
    bol_pkg::t_slot  slot  [N];
    logic [N-1:0]    valid_vec;
    bol_pkg::t_op    op;

    logic                     accept;
    logic                     full;
    logic [bol_pkg::CNT_W-1:0] r_count;
    logic [bol_pkg::CNT_W-1:0] n_count;
    logic                     r_valid;
    bol_pkg::t_status         r_status;
    bol_pkg::t_status         n_status;

    // The cell row finishes every beat as it is taken, so never hold off a start.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Last cell valid means every position is taken.
    assign full = slot[N-1].valid;

    // Broadcast the command; drop inserts into a full list here.
    always_comb begin
        op.cmd   = i_item.cmd;
        op.value = i_item.value;
        op.rem   = accept && (i_item.cmd == bol_pkg::CMD_REMOVE);
        op.ins   = accept && (i_item.cmd != bol_pkg::CMD_REMOVE) && !full;
    end

    assign found[0] = 1'b0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        bol_pkg::t_slot left_slot;
        bol_pkg::t_slot right_slot;

        // Cell zero never takes its left neighbor: found into it is always low.
        if (g == 0) begin : g_first
            assign left_slot = '0;
        end else begin : g_mid
            assign left_slot = slot[g-1];
        end

        // Past the tail, shift in an empty entry on remove.
        if (g == N - 1) begin : g_last
            assign right_slot = '0;
        end else begin : g_inner
            assign right_slot = slot[g+1];
        end

        bol_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (op),
            .i_found (found[g]),
            .o_found (found[g+1]),
            .i_left  (left_slot),
            .i_right (right_slot),
            .o_slot  (slot[g])
        );

        assign valid_vec[g] = slot[g].valid;
    end

    // Status and count for this beat.
    always_comb begin
        n_count  = r_count;
        n_status = bol_pkg::ST_DONE;
        if (op.rem) begin
            if (found[N]) begin
                n_count = r_count - 1'b1;
            end else begin
                n_status = bol_pkg::ST_NOT_FOUND;
            end
        end else if (accept) begin
            if (full) begin
                n_status = bol_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= accept;
        end
        r_status <= n_status;
    end

    assign o_valid         = r_valid;
    assign o_result.status = r_status;
    assign o_result.count  = bol_pkg::COUNT_W'(r_count);

    `BOL_ASSERT_NEXT(a_result_follows_beat, accept, o_valid, "no result after accepted beat")
    `BOL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= bol_pkg::CNT_W'(N), "count above capacity")
    `BOL_ASSERT_NOW(a_count_matches_cells, 1'b1,
                    $countones(valid_vec) == int'(r_count), "count disagrees with cells")
    `BOL_ASSERT_NOW(a_full_count, o_valid && (o_result.status == bol_pkg::ST_FULL),
                    r_count == bol_pkg::CNT_W'(N), "full status with list not full")

endmodule

// File: rtl/bol_cell.sv
// ----------------------------------------------------------------------------
// bol_cell
// One list position: holds an entry, marks itself, shifts with its neighbors.
// ----------------------------------------------------------------------------
module bol_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bol_pkg::t_op   i_op,
    input  logic           i_found,
    output logic           o_found,
    input  bol_pkg::t_slot i_left,
    input  bol_pkg::t_slot i_right,
    output bol_pkg::t_slot o_slot
);

    bol_pkg::t_slot r_slot;
    bol_pkg::t_slot n_slot;
    logic           mark;

    // Does the operation land here (insert point or first match)?
    always_comb begin
        if (i_op.rem) begin
            mark = r_slot.valid && (r_slot.value == i_op.value);
        end else begin
            unique case (i_op.cmd)
                bol_pkg::CMD_INS_ORDERED: mark = !r_slot.valid || (r_slot.value <= i_op.value);
                bol_pkg::CMD_INS_FRONT:   mark = 1'b1;
                bol_pkg::CMD_INS_BACK:    mark = !r_slot.valid;
                default:                  mark = 1'b0;
            endcase
        end
    end

    assign o_found = i_found | mark;

    always_comb begin
        n_slot = r_slot;
        if (i_op.ins) begin
            if (i_found) begin
                n_slot = i_left;
            end else if (mark) begin
                n_slot.valid = 1'b1;
                n_slot.value = i_op.value;
            end
        end else if (i_op.rem && o_found) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.value <= n_slot.value;
    end

    assign o_slot = r_slot;

endmodule
